// ===== rtl/lzt_pkg.sv =====
// Package for the lens zoom table interpolator: lens table, arithmetic constants and latency.
package lzt_pkg;

    // Lens table geometry and field widths.
    localparam int LZT_ROWS   = 18;
    localparam int STEP_W     = 7;
    localparam int FLEN_W     = 16;
    localparam int VIEW_W     = 6;
    localparam int EFL_W      = 19;
    localparam int RATIO_W    = 7;

    // Lens table: zoom step, focal length in micrometers, field of view in degrees.
    localparam logic [STEP_W-1:0] LZT_STEP [LZT_ROWS] = '{
        7'd0,   7'd1,   7'd2,   7'd3,   7'd4,   7'd5,   7'd7,   7'd9,   7'd11,
        7'd14,  7'd19,  7'd41,  7'd64,  7'd72,  7'd86,  7'd105, 7'd107, 7'd124
    };
    localparam logic [FLEN_W-1:0] LZT_FLEN [LZT_ROWS] = '{
        16'd6500,  16'd6803,  16'd6934,  16'd7067,  16'd7203,  16'd7340,
        16'd7620,  16'd7908,  16'd8207,  16'd8665,  16'd9472,  16'd13743,
        16'd20189, 16'd23145, 16'd29387, 16'd40494, 16'd41960, 16'd65000
    };
    localparam logic [VIEW_W-1:0] LZT_VIEW [LZT_ROWS] = '{
        6'd48, 6'd46, 6'd45, 6'd44, 6'd44, 6'd43, 6'd41, 6'd40, 6'd39,
        6'd37, 6'd34, 6'd24, 6'd16, 6'd14, 6'd11, 6'd8,  6'd8,  6'd5
    };

    // Equivalent focal length: focal length times 6035, divided by 1000.
    // The division is a shift by 3 followed by a reciprocal multiply for 125.
    localparam logic [12:0] EFL_MUL       = 13'd6035;
    localparam int          EFL_DIV       = 1000;
    localparam int          EFL_PRE_SHIFT = 3;
    localparam int          EFL_ODD       = EFL_DIV / 8;
    localparam int          EFL_SHIFT     = 33;
    localparam logic [26:0] EFL_RECIP     =
        27'(((64'd1 << EFL_SHIFT) + 64'(EFL_ODD) - 64'd1) / 64'(EFL_ODD));

    // Zoom ratio in tenths: focal length times 10 over the first row's focal length,
    // which equals the focal length divided by a tenth of the first row's focal length.
    localparam int          RATIO_DIV     = int'(LZT_FLEN[0]) / 10;
    localparam int          RATIO_SHIFT   = 26;
    localparam logic [16:0] RATIO_RECIP   =
        17'(((64'd1 << RATIO_SHIFT) + 64'(RATIO_DIV) - 64'd1) / 64'(RATIO_DIV));

    // Divider pipeline: 16 quotient bits, two bits per stage.
    localparam int DIV_STAGES = 8;

    // Cycles from an accepted beat to its result strobe.
    localparam int LZT_LATENCY = DIV_STAGES + 6;

endpackage

// ===== rtl/lens_zoom_table_interpolator.sv =====
// Lens zoom table interpolator: pipelined table lookup, interpolation and derived values.
//
// One zoom step is taken per clock cycle: start with busy low is an accepted beat, and busy is
// always low. Each result appears on the result ports with done high for exactly one cycle,
// in order of acceptance. The receiver cannot stall the block. Latency is set by the
// eight-stage radix-4 divider that turns the interpolation products into quotients; the
// input register, segment select, the product, the final add and the two constant scalings
// take one stage each.
module lens_zoom_table_interpolator
    import lzt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [STEP_W-1:0]    zoom_step,
    output logic                 done,
    output logic [FLEN_W-1:0]    focal_length,
    output logic [VIEW_W-1:0]    field_of_view,
    output logic [EFL_W-1:0]     equivalent_focal_length,
    output logic [RATIO_W-1:0]   zoom_ratio_tenths
);

    // One long division step: {remainder, dividend bits} shifts left by one, quotient bit in.
    function automatic logic [22:0] div_step(input logic [22:0] w, input logic [6:0] d);
        logic [7:0]  t;
        logic [7:0]  diff;
        logic [22:0] r;
        begin
            t    = w[22:15];
            diff = t - {1'b0, d};
            if (t >= {1'b0, d})
            begin
                r = {diff[6:0], w[14:0], 1'b1};
            end
            else
            begin
                r = {t[6:0], w[14:0], 1'b0};
            end
            return r;
        end
    endfunction

    // The block never refuses a beat.
    assign busy = 1'b0;

    // Stage A: capture the accepted step.
    logic                 va_reg;
    logic [STEP_W-1:0]    step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else
        begin
            va_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= zoom_step;
    end

    // Stage B: find the segment around the step. Below the first row or past the last row the
    // offset is zero, so the row's own values pass through unchanged.
    logic                 found;
    logic [FLEN_W-1:0]    base_flen_next;
    logic [VIEW_W-1:0]    base_view_next;
    logic [STEP_W-1:0]    off_next;
    logic [STEP_W-1:0]    span_next;
    logic [FLEN_W-1:0]    dflen_next;
    logic [VIEW_W-1:0]    dview_next;

    always_comb
    begin
        found          = 1'b0;
        base_flen_next = LZT_FLEN[LZT_ROWS-1];
        base_view_next = LZT_VIEW[LZT_ROWS-1];
        off_next       = '0;
        span_next      = STEP_W'(1);
        dflen_next     = '0;
        dview_next     = '0;
        if (step_reg <= LZT_STEP[0])
        begin
            base_flen_next = LZT_FLEN[0];
            base_view_next = LZT_VIEW[0];
        end
        else
        begin
            for (int k = 1; k < LZT_ROWS; k++)
            begin
                if (!found && (step_reg <= LZT_STEP[k]))
                begin
                    found          = 1'b1;
                    base_flen_next = LZT_FLEN[k-1];
                    base_view_next = LZT_VIEW[k-1];
                    off_next       = step_reg - LZT_STEP[k-1];
                    span_next      = LZT_STEP[k] - LZT_STEP[k-1];
                    dflen_next     = LZT_FLEN[k] - LZT_FLEN[k-1];
                    dview_next     = LZT_VIEW[k-1] - LZT_VIEW[k];
                end
            end
        end
    end

    logic                 vb_reg;
    logic [FLEN_W-1:0]    base_flen_reg;
    logic [VIEW_W-1:0]    base_view_reg;
    logic [STEP_W-1:0]    off_reg;
    logic [STEP_W-1:0]    span_reg;
    logic [FLEN_W-1:0]    dflen_reg;
    logic [VIEW_W-1:0]    dview_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else
        begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        base_flen_reg <= base_flen_next;
        base_view_reg <= base_view_next;
        off_reg       <= off_next;
        span_reg      <= span_next;
        dflen_reg     <= dflen_next;
        dview_reg     <= dview_next;
    end

    // Stage C: interpolation products. Each is below span times 2^16, so the divider starts with
    // the top seven bits as its remainder.
    logic [22:0]          nf_next;
    logic [22:0]          nv_next;

    assign nf_next = 23'(off_reg) * 23'(dflen_reg);
    assign nv_next = 23'(off_reg) * 23'(dview_reg);

    logic                 vdiv_reg   [DIV_STAGES+1];
    logic [22:0]          wf_reg     [DIV_STAGES+1];
    logic [22:0]          wv_reg     [DIV_STAGES+1];
    logic [STEP_W-1:0]    dspan_reg  [DIV_STAGES+1];
    logic [FLEN_W-1:0]    dflen0_reg [DIV_STAGES+1];
    logic [VIEW_W-1:0]    dview0_reg [DIV_STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vdiv_reg[0] <= 1'b0;
        end
        else
        begin
            vdiv_reg[0] <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wf_reg[0]     <= nf_next;
        wv_reg[0]     <= nv_next;
        dspan_reg[0]  <= span_reg;
        dflen0_reg[0] <= base_flen_reg;
        dview0_reg[0] <= base_view_reg;
    end

    // Divider stages: two quotient bits each for both products.
    genvar i;
    generate
        for (i = 0; i < DIV_STAGES; i++)
        begin : g_div
            logic [22:0] wf_next;
            logic [22:0] wv_next;

            assign wf_next = div_step(div_step(wf_reg[i], dspan_reg[i]), dspan_reg[i]);
            assign wv_next = div_step(div_step(wv_reg[i], dspan_reg[i]), dspan_reg[i]);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vdiv_reg[i+1] <= 1'b0;
                end
                else
                begin
                    vdiv_reg[i+1] <= vdiv_reg[i];
                end
            end

            always_ff @(posedge clk)
            begin
                wf_reg[i+1]     <= wf_next;
                wv_reg[i+1]     <= wv_next;
                dspan_reg[i+1]  <= dspan_reg[i];
                dflen0_reg[i+1] <= dflen0_reg[i];
                dview0_reg[i+1] <= dview0_reg[i];
            end
        end
    endgenerate

    // Stage D: apply the quotients to the lower row's values.
    logic                 vd_reg;
    logic [FLEN_W-1:0]    fl_d_reg;
    logic [VIEW_W-1:0]    fov_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg <= 1'b0;
        end
        else
        begin
            vd_reg <= vdiv_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        fl_d_reg  <= dflen0_reg[DIV_STAGES] + wf_reg[DIV_STAGES][FLEN_W-1:0];
        fov_d_reg <= dview0_reg[DIV_STAGES] - wv_reg[DIV_STAGES][VIEW_W-1:0];
    end

    // Stage E: scale for the equivalent focal length and the reciprocal multiply for the ratio.
    logic [28:0]          efl_prod_next;
    logic [32:0]          ratio_full;

    assign efl_prod_next = 29'(fl_d_reg) * 29'(EFL_MUL);
    assign ratio_full    = 33'(fl_d_reg) * 33'(RATIO_RECIP);

    logic                 ve_reg;
    logic [28:0]          efl_prod_reg;
    logic [RATIO_W-1:0]   ratio_e_reg;
    logic [FLEN_W-1:0]    fl_e_reg;
    logic [VIEW_W-1:0]    fov_e_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ve_reg <= 1'b0;
        end
        else
        begin
            ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        efl_prod_reg <= efl_prod_next;
        ratio_e_reg  <= ratio_full[RATIO_SHIFT+RATIO_W-1:RATIO_SHIFT];
        fl_e_reg     <= fl_d_reg;
        fov_e_reg    <= fov_d_reg;
    end

    // Output stage: divide the scaled focal length by 1000 and present the result beat.
    logic [52:0]          efl_full;

    assign efl_full = 53'(efl_prod_reg[28:EFL_PRE_SHIFT]) * 53'(EFL_RECIP);

    logic                 done_reg;
    logic [FLEN_W-1:0]    fl_out_reg;
    logic [VIEW_W-1:0]    fov_out_reg;
    logic [EFL_W-1:0]     efl_out_reg;
    logic [RATIO_W-1:0]   ratio_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ve_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fl_out_reg    <= fl_e_reg;
        fov_out_reg   <= fov_e_reg;
        efl_out_reg   <= efl_full[EFL_SHIFT+EFL_W-1:EFL_SHIFT];
        ratio_out_reg <= ratio_e_reg;
    end

    assign done                    = done_reg;
    assign focal_length            = fl_out_reg;
    assign field_of_view           = fov_out_reg;
    assign equivalent_focal_length = efl_out_reg;
    assign zoom_ratio_tenths       = ratio_out_reg;

endmodule

// ===== rtl/lzt_checker.sv =====
// Port-level checker for the lens zoom table interpolator, bound to the top level.
module lzt_checker
    import lzt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [STEP_W-1:0]    zoom_step,
    input  logic                 done,
    input  logic [FLEN_W-1:0]    focal_length,
    input  logic [VIEW_W-1:0]    field_of_view,
    input  logic [EFL_W-1:0]     equivalent_focal_length,
    input  logic [RATIO_W-1:0]   zoom_ratio_tenths
);

    // Every accepted beat yields its result after the fixed latency.
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LZT_LATENCY done)
        else $error("accepted beat produced no result at the expected cycle");

    // No result appears without a beat accepted at the matching cycle.
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LZT_LATENCY))
        else $error("result strobe without a matching accepted beat");

    // A first-row step gives the first row's focal length and a ratio of ten tenths.
    a_first_row: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(zoom_step == 7'd0, LZT_LATENCY)) |->
            (focal_length == LZT_FLEN[0]) && (zoom_ratio_tenths == 7'd10))
        else $error("first row lookup returned wrong values");

    // Results stay inside the lens table's range.
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (focal_length >= 16'd6500) && (focal_length <= 16'd65000)
            && (field_of_view >= 6'd5) && (field_of_view <= 6'd48)
            && (zoom_ratio_tenths >= 7'd10) && (zoom_ratio_tenths <= 7'd100)
            && (equivalent_focal_length >= 19'd39227)
            && (equivalent_focal_length <= 19'd392275))
        else $error("result outside the lens table range");

endmodule

bind lens_zoom_table_interpolator lzt_checker u_lzt_checker (.*);
